### src/drsm_pkg.sv
// Shared types and constants for the descriptor ring slot manager.
package drsm_pkg;

  localparam int MAX_ENTRIES    = 64;
  localparam int NUM_SLOTS      = MAX_ENTRIES - 1;
  localparam int SLOT_W         = $clog2(NUM_SLOTS);
  localparam int DEPTH_W        = 7;
  localparam int LEN_W          = 12;
  localparam int TYPE_W         = 8;
  localparam int ADDR_W         = 40;
  localparam int PROD_W         = SLOT_W + LEN_W;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = ADDR_W;

  localparam logic [DEPTH_W-1:0] MIN_DEPTH      = 7'd2;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH      = 7'd64;
  localparam logic [LEN_W-1:0]   MAX_BUF_BYTES  = 12'd2048;
  localparam logic [TYPE_W-1:0]  RST_TYPE       = 8'd0;
  localparam logic [LEN_W-1:0]   RST_LEN        = 12'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_BYTES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_CODE  = 3'd4;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ENQ   = 2'd1;
  localparam logic [1:0] CMD_FIND  = 2'd2;
  localparam logic [1:0] CMD_WBACK = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_SLOT = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [LEN_W-1:0]  pkt_len;
    logic [SLOT_W-1:0] slot_sel;
    logic [TYPE_W-1:0] type_code;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_found;
    logic [ADDR_W-1:0] buffer_addr;
    logic [LEN_W-1:0]  slot_length;
  } out_word_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] ring_size;
    logic [LEN_W-1:0]   buf_bytes;
    logic [ADDR_W-1:0]  pool_base;
    logic [TYPE_W-1:0]  empty_code;
    logic [TYPE_W-1:0]  full_code;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [TYPE_W-1:0] wtype;
    logic [LEN_W-1:0]  wlen;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [TYPE_W-1:0] rtype;
    logic [LEN_W-1:0]  rlen;
  } ram_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_WR,
    S_TAIL_MOD,
    S_SCAN,
    S_ADDR_MUL,
    S_ADDR_ADD,
    S_RESP
  } state_t;

endpackage

### src/drsm_slot_ram.sv
// Slot descriptor store: one write port, one registered read port, per-slot valid bits.
module drsm_slot_ram (
  input  logic                clk,
  input  logic                rst_n,
  input  drsm_pkg::ram_req_t  req,
  output drsm_pkg::ram_rsp_t  rsp
);

  logic [drsm_pkg::TYPE_W+drsm_pkg::LEN_W-1:0] mem [drsm_pkg::NUM_SLOTS];
  logic [drsm_pkg::NUM_SLOTS-1:0]               vld_r;
  logic [drsm_pkg::TYPE_W+drsm_pkg::LEN_W-1:0] rd_data_r;
  logic                                         rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= {req.wtype, req.wlen};
    end
    rd_data_r <= mem[req.raddr];
  end

  // A slot never written since reset reads as the reset descriptor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[req.raddr];
    end
  end

  assign rsp.rtype = rd_vld_r ? rd_data_r[drsm_pkg::TYPE_W+drsm_pkg::LEN_W-1:drsm_pkg::LEN_W]
                              : drsm_pkg::RST_TYPE;
  assign rsp.rlen  = rd_vld_r ? rd_data_r[drsm_pkg::LEN_W-1:0] : drsm_pkg::RST_LEN;

endmodule

### src/drsm_ctrl.sv
// Command sequencer: init sweep, tail reduction, pipelined slot scan, write-back and address calculation.
module drsm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  drsm_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output drsm_pkg::out_word_t  out_data,
  input  drsm_pkg::cfg_t       cfg,
  output drsm_pkg::ram_req_t   ram_req,
  input  drsm_pkg::ram_rsp_t   ram_rsp
);

  drsm_pkg::state_t            state_r, state_nxt;
  drsm_pkg::in_word_t          op_r, op_nxt;
  logic [drsm_pkg::SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [drsm_pkg::SLOT_W-1:0] idx_r, idx_nxt;
  logic                        chk_v_r, chk_v_nxt;
  logic [drsm_pkg::SLOT_W-1:0] chk_slot_r, chk_slot_nxt;
  logic                        chk_last_r, chk_last_nxt;
  logic [drsm_pkg::TYPE_W-1:0] code_r, code_nxt;
  logic [1:0]                  res_status_r, res_status_nxt;
  logic [drsm_pkg::SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [drsm_pkg::LEN_W-1:0]  res_len_r, res_len_nxt;
  logic [drsm_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [drsm_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [drsm_pkg::SLOT_W-1:0] tail_r, tail_nxt;
  logic                        out_valid_r, out_valid_nxt;
  drsm_pkg::out_word_t         out_data_r, out_data_nxt;

  logic                         depth_ok;
  logic [drsm_pkg::DEPTH_W-1:0] n_full;
  logic [drsm_pkg::SLOT_W-1:0]  n;
  logic [drsm_pkg::DEPTH_W-1:0] idx_inc;
  logic [drsm_pkg::DEPTH_W-1:0] cnt_inc;
  logic [drsm_pkg::DEPTH_W-1:0] chk_inc;
  logic                         accept;

  assign depth_ok = (cfg.ring_size >= drsm_pkg::MIN_DEPTH) &&
                    (cfg.ring_size <= drsm_pkg::MAX_DEPTH);
  assign n_full   = cfg.ring_size - 7'd1;
  assign n        = n_full[drsm_pkg::SLOT_W-1:0];
  assign idx_inc  = {1'b0, idx_r} + 7'd1;
  assign cnt_inc  = {1'b0, cnt_r} + 7'd1;
  assign chk_inc  = {1'b0, chk_slot_r} + 7'd1;
  assign accept   = in_valid && !in_stall;

  assign in_stall  = (state_r != drsm_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drsm_pkg::S_IDLE;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      chk_v_r     <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    cnt_r        <= cnt_nxt;
    idx_r        <= idx_nxt;
    chk_slot_r   <= chk_slot_nxt;
    chk_last_r   <= chk_last_nxt;
    code_r       <= code_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_len_r    <= res_len_nxt;
    prod_r       <= prod_nxt;
    addr_r       <= addr_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    chk_v_nxt      = 1'b0;
    chk_slot_nxt   = chk_slot_r;
    chk_last_nxt   = chk_last_r;
    code_nxt       = code_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_len_nxt    = res_len_r;
    prod_nxt       = prod_r;
    addr_nxt       = addr_r;
    tail_nxt       = tail_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    ram_req.we     = 1'b0;
    ram_req.waddr  = cnt_r;
    ram_req.wtype  = cfg.empty_code;
    ram_req.wlen   = cfg.buf_bytes;
    ram_req.raddr  = idx_r;

    case (state_r)
      drsm_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt         = in_data;
          res_status_nxt = drsm_pkg::ST_INVALID;
          res_slot_nxt   = '0;
          res_len_nxt    = '0;
          addr_nxt       = '0;
          cnt_nxt        = '0;
          state_nxt      = drsm_pkg::S_RESP;
          if (depth_ok) begin
            case (in_data.cmd)
              drsm_pkg::CMD_INIT: begin
                if (cfg.buf_bytes <= drsm_pkg::MAX_BUF_BYTES) begin
                  res_status_nxt = drsm_pkg::ST_OK;
                  state_nxt      = drsm_pkg::S_INIT_WR;
                end
              end
              drsm_pkg::CMD_ENQ: begin
                if (in_data.pkt_len != '0 && in_data.pkt_len <= cfg.buf_bytes) begin
                  idx_nxt   = tail_r;
                  code_nxt  = cfg.empty_code;
                  state_nxt = drsm_pkg::S_TAIL_MOD;
                end
              end
              drsm_pkg::CMD_FIND: begin
                if ({1'b0, in_data.slot_sel} < n_full) begin
                  idx_nxt   = in_data.slot_sel;
                  code_nxt  = in_data.type_code;
                  state_nxt = drsm_pkg::S_SCAN;
                end
              end
              drsm_pkg::CMD_WBACK: begin
                if ({1'b0, in_data.slot_sel} < n_full) begin
                  ram_req.we     = 1'b1;
                  ram_req.waddr  = in_data.slot_sel;
                  ram_req.wtype  = in_data.type_code;
                  ram_req.wlen   = in_data.pkt_len;
                  res_status_nxt = drsm_pkg::ST_OK;
                  res_slot_nxt   = in_data.slot_sel;
                  res_len_nxt    = in_data.pkt_len;
                  state_nxt      = drsm_pkg::S_ADDR_MUL;
                end
              end
              default: begin
                state_nxt = drsm_pkg::S_RESP;
              end
            endcase
          end
        end
      end

      drsm_pkg::S_INIT_WR: begin
        ram_req.we = 1'b1;
        cnt_nxt    = cnt_inc[drsm_pkg::SLOT_W-1:0];
        if (cnt_inc == n_full) begin
          state_nxt = drsm_pkg::S_RESP;
        end
      end

      // The tail may be stale after a depth change, so reduce it by repeated subtraction.
      drsm_pkg::S_TAIL_MOD: begin
        if (idx_r >= n) begin
          idx_nxt = idx_r - n;
        end else begin
          cnt_nxt   = '0;
          state_nxt = drsm_pkg::S_SCAN;
        end
      end

      // One read is issued per cycle; the slot read in the previous cycle is checked.
      drsm_pkg::S_SCAN: begin
        if (chk_v_r && ram_rsp.rtype == code_r) begin
          res_status_nxt = drsm_pkg::ST_OK;
          res_slot_nxt   = chk_slot_r;
          state_nxt      = drsm_pkg::S_ADDR_MUL;
          if (op_r.cmd == drsm_pkg::CMD_ENQ) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = chk_slot_r;
            ram_req.wtype = cfg.full_code;
            ram_req.wlen  = op_r.pkt_len;
            res_len_nxt   = op_r.pkt_len;
            tail_nxt      = (chk_inc == n_full) ? '0 : chk_inc[drsm_pkg::SLOT_W-1:0];
          end else begin
            res_len_nxt = ram_rsp.rlen;
          end
        end else if (chk_v_r && chk_last_r) begin
          res_status_nxt = drsm_pkg::ST_NO_SLOT;
          state_nxt      = drsm_pkg::S_RESP;
        end else if ({1'b0, cnt_r} < n_full) begin
          chk_v_nxt    = 1'b1;
          chk_slot_nxt = idx_r;
          chk_last_nxt = (cnt_inc == n_full);
          cnt_nxt      = cnt_inc[drsm_pkg::SLOT_W-1:0];
          idx_nxt      = (idx_inc == n_full) ? '0 : idx_inc[drsm_pkg::SLOT_W-1:0];
        end
      end

      drsm_pkg::S_ADDR_MUL: begin
        prod_nxt  = {{drsm_pkg::LEN_W{1'b0}}, res_slot_r} *
                    {{drsm_pkg::SLOT_W{1'b0}}, cfg.buf_bytes};
        state_nxt = drsm_pkg::S_ADDR_ADD;
      end

      drsm_pkg::S_ADDR_ADD: begin
        addr_nxt  = cfg.pool_base +
                    {{(drsm_pkg::ADDR_W - drsm_pkg::PROD_W){1'b0}}, prod_r};
        state_nxt = drsm_pkg::S_RESP;
      end

      drsm_pkg::S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.slot_found  = res_slot_r;
          out_data_nxt.buffer_addr = addr_r;
          out_data_nxt.slot_length = res_len_r;
          state_nxt                = drsm_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = drsm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### src/descriptor_ring_slot_manager.sv
// Flow from the accepted word to the result: init writes the n = ring_size-1 data slots,
// one slot write per cycle; find reads one slot per cycle, then does the address math;
// enqueue is a find preceded by tail reduction after a depth change; write-back as find's math.
// One word is processed at a time; the next is taken once the result is registered, and a
// result held by out_stall only delays the release of the next one.
// Reset (synchronous, rst_n low) restores register defaults, tail zero, slots type/length 0.
module descriptor_ring_slot_manager (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  drsm_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output drsm_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [drsm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [drsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  drsm_pkg::cfg_t     cfg_r, cfg_nxt;
  drsm_pkg::ram_req_t ram_req;
  drsm_pkg::ram_rsp_t ram_rsp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        drsm_pkg::CFG_RING_SIZE:  cfg_nxt.ring_size  = cfg_wdata[drsm_pkg::DEPTH_W-1:0];
        drsm_pkg::CFG_BUF_BYTES:  cfg_nxt.buf_bytes  = cfg_wdata[drsm_pkg::LEN_W-1:0];
        drsm_pkg::CFG_POOL_BASE:  cfg_nxt.pool_base  = cfg_wdata[drsm_pkg::ADDR_W-1:0];
        drsm_pkg::CFG_EMPTY_CODE: cfg_nxt.empty_code = cfg_wdata[drsm_pkg::TYPE_W-1:0];
        drsm_pkg::CFG_FULL_CODE:  cfg_nxt.full_code  = cfg_wdata[drsm_pkg::TYPE_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ring_size  <= drsm_pkg::MAX_DEPTH;
      cfg_r.buf_bytes  <= drsm_pkg::MAX_BUF_BYTES;
      cfg_r.pool_base  <= '0;
      cfg_r.empty_code <= 8'd0;
      cfg_r.full_code  <= 8'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  drsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg       (cfg_r),
    .ram_req   (ram_req),
    .ram_rsp   (ram_rsp)
  );

  drsm_slot_ram u_slot_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rsp   (ram_rsp)
  );

endmodule

### dv/descriptor_ring_slot_manager_tb.sv
// Self-checking testbench for the descriptor ring slot manager, with its own ring predictor.
`timescale 1ns / 100ps

module descriptor_ring_slot_manager_tb;
  import drsm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_SETTLE     = 150;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  descriptor_ring_slot_manager dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow of the ring: slot types, slot lengths, tail and the register settings.
  logic [TYPE_W-1:0] ring_type [NUM_SLOTS];
  logic [LEN_W-1:0]  ring_len  [NUM_SLOTS];
  int unsigned       ring_tail;
  cfg_t              ring_cfg;

  out_word_t pending_results [$];
  int        errors           = 0;
  int        words_sent       = 0;
  int        results_checked  = 0;
  int        settings_applied = 0;
  int        quiet_cycles     = 0;
  int        stall_left       = 0;
  bit        idle_on          = 1'b1;
  out_word_t want;

  function automatic logic [ADDR_W-1:0] buffer_addr_of(int unsigned slot);
    logic [63:0] sum;
    sum = 64'(ring_cfg.pool_base) + 64'(slot) * 64'(ring_cfg.buf_bytes);
    return sum[ADDR_W-1:0];
  endfunction

  // First slot holding code, scanning n slots from start with wrap; n when none matches.
  function automatic int unsigned first_slot_of(int unsigned n, int unsigned start,
                                                logic [TYPE_W-1:0] code);
    int unsigned s;
    for (int unsigned i = 0; i < n; i++) begin
      s = (start + i) % n;
      if (ring_type[s] == code) return s;
    end
    return n;
  endfunction

  function automatic out_word_t ring_response(in_word_t w);
    out_word_t   r;
    int unsigned n;
    int unsigned s;
    r = '0;
    if (ring_cfg.ring_size < MIN_DEPTH || ring_cfg.ring_size > MAX_DEPTH) begin
      r.status = ST_INVALID;
      return r;
    end
    n = ring_cfg.ring_size - 1;
    case (w.cmd)
      CMD_INIT: begin
        if (ring_cfg.buf_bytes > MAX_BUF_BYTES) begin
          r.status = ST_INVALID;
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            ring_type[i] = ring_cfg.empty_code;
            ring_len[i]  = ring_cfg.buf_bytes;
          end
          r.status = ST_OK;
        end
      end
      CMD_ENQ: begin
        if (w.pkt_len == '0 || w.pkt_len > ring_cfg.buf_bytes) begin
          r.status = ST_INVALID;
        end else begin
          // A tail left over from a deeper ring is folded into the current one.
          s = first_slot_of(n, ring_tail % n, ring_cfg.empty_code);
          if (s >= n) begin
            r.status = ST_NO_SLOT;
          end else begin
            ring_len[s]   = w.pkt_len;
            ring_type[s]  = ring_cfg.full_code;
            ring_tail     = (s + 1) % n;
            r.status      = ST_OK;
            r.slot_found  = SLOT_W'(s);
            r.buffer_addr = buffer_addr_of(s);
            r.slot_length = w.pkt_len;
          end
        end
      end
      CMD_FIND: begin
        if (w.slot_sel >= n) begin
          r.status = ST_INVALID;
        end else begin
          s = first_slot_of(n, w.slot_sel, w.type_code);
          if (s >= n) begin
            r.status = ST_NO_SLOT;
          end else begin
            r.status      = ST_OK;
            r.slot_found  = SLOT_W'(s);
            r.buffer_addr = buffer_addr_of(s);
            r.slot_length = ring_len[s];
          end
        end
      end
      default: begin
        if (w.slot_sel >= n) begin
          r.status = ST_INVALID;
        end else begin
          ring_type[w.slot_sel] = w.type_code;
          ring_len[w.slot_sel]  = w.pkt_len;
          r.status      = ST_OK;
          r.slot_found  = w.slot_sel;
          r.buffer_addr = buffer_addr_of(w.slot_sel);
          r.slot_length = w.pkt_len;
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_word_t make_word(logic [1:0] cmd, logic [LEN_W-1:0] len,
                                         logic [SLOT_W-1:0] sel, logic [TYPE_W-1:0] code);
    in_word_t w;
    w.cmd       = cmd;
    w.pkt_len   = len;
    w.slot_sel  = sel;
    w.type_code = code;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(ring_response(w));
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [DEPTH_W-1:0] depth, input logic [LEN_W-1:0] bytes,
                              input logic [ADDR_W-1:0] base, input logic [TYPE_W-1:0] ecode,
                              input logic [TYPE_W-1:0] fcode);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_RING_SIZE;
    cfg_wdata <= CFG_DATA_W'(depth);
    @(posedge clk);
    cfg_idx   <= CFG_BUF_BYTES;
    cfg_wdata <= CFG_DATA_W'(bytes);
    @(posedge clk);
    cfg_idx   <= CFG_POOL_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_idx   <= CFG_EMPTY_CODE;
    cfg_wdata <= CFG_DATA_W'(ecode);
    @(posedge clk);
    cfg_idx   <= CFG_FULL_CODE;
    cfg_wdata <= CFG_DATA_W'(fcode);
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_cfg.ring_size  = depth;
    ring_cfg.buf_bytes  = bytes;
    ring_cfg.pool_base  = base;
    ring_cfg.empty_code = ecode;
    ring_cfg.full_code  = fcode;
    settings_applied++;
  endtask

  // Power-on settings: slots never touched by init, so finds and enqueues see type zero.
  task automatic test_reset_state();
    send_word(make_word(CMD_FIND, 12'd0, 6'd62, 8'd0));
    send_word(make_word(CMD_ENQ, MAX_BUF_BYTES, 6'd0, 8'd0));
    send_word(make_word(CMD_ENQ, 12'd0, 6'd0, 8'd0));
    send_word(make_word(CMD_FIND, 12'd0, 6'd63, 8'd0));
    send_word(make_word(CMD_WBACK, 12'd9, 6'd63, 8'd9));
    send_word(make_word(CMD_WBACK, 12'hFFF, 6'd62, 8'hFF));
    send_word(make_word(CMD_FIND, 12'd0, 6'd0, 8'hFF));
    send_word(make_word(CMD_INIT, 12'd0, 6'd0, 8'd0));
  endtask

  task automatic test_bad_config();
    apply_config(7'd0, MAX_BUF_BYTES, '0, 8'd0, 8'd1);
    send_word(make_word(CMD_INIT, 12'd0, 6'd0, 8'd0));
    apply_config(MIN_DEPTH - 7'd1, MAX_BUF_BYTES, '0, 8'd0, 8'd1);
    send_word(make_word(CMD_ENQ, 12'd1, 6'd0, 8'd0));
    apply_config(MAX_DEPTH + 7'd1, MAX_BUF_BYTES, '0, 8'd0, 8'd1);
    send_word(make_word(CMD_FIND, 12'd0, 6'd0, 8'd0));
    apply_config(7'h7F, MAX_BUF_BYTES, '0, 8'd0, 8'd1);
    send_word(make_word(CMD_WBACK, 12'd3, 6'd0, 8'd3));
    apply_config(MAX_DEPTH, 12'hFFF, '0, 8'd0, 8'd1);
    send_word(make_word(CMD_INIT, 12'd0, 6'd0, 8'd0));
    // Zero-byte slots are accepted by init, but then no frame length fits.
    apply_config(MAX_DEPTH, 12'd0, '0, 8'd0, 8'd1);
    send_word(make_word(CMD_INIT, 12'd0, 6'd0, 8'd0));
    send_word(make_word(CMD_ENQ, 12'd1, 6'd0, 8'd0));
  endtask

  // Buffers near the top of the address space wrap; a shallower ring keeps the old tail.
  task automatic test_wrap_and_stale_tail();
    apply_config(7'd8, MAX_BUF_BYTES, ADDR_MAX - 40'd4095, 8'hFF, 8'h00);
    send_word(make_word(CMD_INIT, 12'd0, 6'd0, 8'd0));
    repeat (6) send_word(make_word(CMD_ENQ, LEN_W'($urandom_range(1, 2048)), 6'd0, 8'd0));
    apply_config(7'd4, MAX_BUF_BYTES, ADDR_MAX - 40'd4095, 8'hFF, 8'h00);
    send_word(make_word(CMD_WBACK, 12'd5, 6'd2, 8'hFF));
    send_word(make_word(CMD_ENQ, 12'd3, 6'd0, 8'd0));
    send_word(make_word(CMD_ENQ, 12'd3, 6'd0, 8'd0));
  endtask

  // With equal codes a claimed slot still looks free.
  task automatic test_equal_codes();
    apply_config(MIN_DEPTH, 12'd1, ADDR_MAX, 8'h5A, 8'h5A);
    send_word(make_word(CMD_INIT, 12'd0, 6'd0, 8'd0));
    send_word(make_word(CMD_ENQ, 12'd1, 6'd0, 8'd0));
    send_word(make_word(CMD_ENQ, 12'd1, 6'd0, 8'd0));
    send_word(make_word(CMD_FIND, 12'd0, 6'd1, 8'h5A));
  endtask

  function automatic logic [TYPE_W-1:0] pick_code(int unsigned n);
    case ($urandom_range(0, 3))
      0:       return ring_cfg.empty_code;
      1:       return ring_cfg.full_code;
      2:       return TYPE_W'($urandom);
      default: return ring_type[$urandom_range(0, n - 1)];
    endcase
  endfunction

  task automatic run_traffic_phase(input int count, input logic [DEPTH_W-1:0] depth);
    logic [LEN_W-1:0]  bytes;
    logic [TYPE_W-1:0] ecode;
    logic [TYPE_W-1:0] fcode;
    int unsigned       n;
    int unsigned       roll;
    logic [LEN_W-1:0]  len;
    in_word_t          w;
    case ($urandom_range(0, 9))
      0:       bytes = 12'd1;
      1:       bytes = MAX_BUF_BYTES;
      2:       bytes = LEN_W'($urandom_range(2049, 4095));
      default: bytes = LEN_W'($urandom_range(1, 2048));
    endcase
    ecode = TYPE_W'($urandom);
    fcode = ($urandom_range(0, 4) == 0) ? ecode : TYPE_W'($urandom);
    apply_config(depth, bytes, ADDR_W'({$urandom, $urandom}), ecode, fcode);
    n = depth - 1;
    if ($urandom_range(0, 4) != 0) send_word(make_word(CMD_INIT, 12'd0, 6'd0, 8'd0));
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        len = (roll < 4) ? LEN_W'($urandom) : LEN_W'($urandom_range(1, bytes));
        w = make_word(CMD_ENQ, len, SLOT_W'($urandom), TYPE_W'($urandom));
      end else if (roll < 70) begin
        w = make_word(CMD_FIND, LEN_W'($urandom), SLOT_W'($urandom_range(0, n - 1)),
                      pick_code(n));
      end else if (roll < 90) begin
        w = make_word(CMD_WBACK, LEN_W'($urandom), SLOT_W'($urandom_range(0, n - 1)),
                      (roll < 80) ? ring_cfg.empty_code : pick_code(n));
      end else if (roll < 93) begin
        w = make_word(CMD_INIT, LEN_W'($urandom), SLOT_W'($urandom), TYPE_W'($urandom));
      end else begin
        w = make_word(2'($urandom), LEN_W'($urandom), SLOT_W'($urandom), TYPE_W'($urandom));
      end
      send_word(w);
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(80, MAX_DEPTH);
    run_traffic_phase(80, MIN_DEPTH);
    run_traffic_phase(80, 7'd3);
    run_traffic_phase(80, 7'd17);
    run_traffic_phase(80, DEPTH_W'($urandom_range(2, 64)));
    idle_on = 1'b0;
    run_traffic_phase(80, DEPTH_W'($urandom_range(2, 12)));
  endtask

  initial begin
    ring_cfg.ring_size  = MAX_DEPTH;
    ring_cfg.buf_bytes  = MAX_BUF_BYTES;
    ring_cfg.pool_base  = '0;
    ring_cfg.empty_code = RST_TYPE;
    ring_cfg.full_code  = 8'd1;
    ring_tail = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ring_type[i] = RST_TYPE;
      ring_len[i]  = RST_LEN;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_bad_config();
    test_wrap_and_stale_tail();
    test_equal_codes();
    test_random_traffic();
    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      errors++;
    end
    $display("Sent %0d command words, checked %0d results over %0d register settings.",
             words_sent, results_checked, settings_applied);
    $display("Run covered init, enqueue, find, write-back, bad settings, wrap and full rings.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side back-pressure in short random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %p", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_data.status));
        check_field("slot_found", 64'(want.slot_found), 64'(out_data.slot_found));
        check_field("buffer_addr", 64'(want.buffer_addr), 64'(out_data.buffer_addr));
        check_field("slot_length", 64'(want.slot_length), 64'(out_data.slot_length));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### descriptor_ring_slot_manager.f
src/drsm_pkg.sv
src/drsm_slot_ram.sv
src/drsm_ctrl.sv
src/descriptor_ring_slot_manager.sv
dv/descriptor_ring_slot_manager_tb.sv
